### hw/rtl/krhm_pkg.sv
`timescale 1ns / 1ps

package krhm_pkg;

  // Fixed field widths of the stream words.
  localparam int KEY_W     = 16;
  localparam int DATA_W    = 64;
  localparam int S_TDATA_W = KEY_W + DATA_W;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = DATA_W;
  localparam int M_TUSER_W = 2;

  // Shared multiplier: a key or quotient by a reciprocal or a bucket count.
  localparam int RECIP_SHIFT = 32;
  localparam int MUL_AW      = KEY_W;
  localparam int MUL_BW      = RECIP_SHIFT + 1;
  localparam int MUL_PW      = MUL_AW + MUL_BW;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef enum logic {
    ST_OK   = 1'b0,
    ST_FULL = 1'b1
  } status_t;

endpackage

### hw/rtl/krhm_ram.sv
`timescale 1ns / 1ps

module krhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/krhm_mul.sv
`timescale 1ns / 1ps

module krhm_mul (
  input  logic                        clk,
  input  logic [krhm_pkg::MUL_AW-1:0] a,
  input  logic [krhm_pkg::MUL_BW-1:0] b,
  output logic [krhm_pkg::MUL_PW-1:0] p
);

  import krhm_pkg::*;

  // One registered product per cycle; the sequencer feeds it twice per word.
  always_ff @(posedge clk) begin
    p <= MUL_PW'(a) * MUL_PW'(b);
  end

endmodule

### hw/rtl/keyed_record_hash_map.sv
`timescale 1ns / 1ps

// Hash map from a 16-bit key to a RECORD_WIDTH-bit record, with separate
// chaining. The bucket of a key is the key modulo BUCKETS; each bucket keeps
// a linked chain of entries handed out in order from a pool of POOL_ENTRIES
// entries. A get (tuser cmd 0) walks the chain and answers hit and the
// stored record; a put (cmd 1) overwrites the record of a matching entry or
// appends a fresh entry; with no match on a used-up pool, status is full.
// One word is handled at a time. After reset the block clears every entry of
// the bucket table before it takes its first word. A word then passes the
// quotient, remainder, bucket and head steps, a walk over the chain (no entry
// for an empty bucket, the whole chain for a miss), the result step and, when
// a put appends an entry, a link step. The walk is the part that varies: each
// visited entry costs one registered read of the entry memories. A result
// still waiting on the master side holds the next operation in its result
// step until it is taken.
module keyed_record_hash_map #(
  parameter int BUCKETS      = 1024,
  parameter int POOL_ENTRIES = 1024,
  parameter int RECORD_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata: key [15:0], record_in [79:16]
  input  logic [krhm_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: cmd [0]
  input  logic [krhm_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata: record_out [63:0]
  output logic [krhm_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser: hit [0], status [1]
  output logic [krhm_pkg::M_TUSER_W-1:0] m_tuser
);

  import krhm_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int HW = 1 + 2 * PW;
  localparam int DW = KEY_W + RECORD_WIDTH;
  localparam int LW = 1 + PW;

  // Reciprocal rounded up; exact quotient for every 16-bit key.
  localparam logic [MUL_BW-1:0] BKT_RECIP =
    MUL_BW'(((64'd1 << RECIP_SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
  localparam logic [MUL_BW-1:0] BKT_MULT  = MUL_BW'(BUCKETS);
  localparam logic [BW-1:0]     BKT_LAST  = BW'(BUCKETS - 1);
  localparam logic [CW-1:0]     POOL_FULL = CW'(POOL_ENTRIES);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_QUOT  = 9'b000000100,
    S_REM   = 9'b000001000,
    S_BKT   = 9'b000010000,
    S_HEAD  = 9'b000100000,
    S_WALK  = 9'b001000000,
    S_DONE  = 9'b010000000,
    S_LINK  = 9'b100000000
  } state_t;

  state_t                  state;
  logic [BW-1:0]           clr_idx;
  cmd_t                    cmd_r;
  logic [KEY_W-1:0]        key_r;
  logic [RECORD_WIDTH-1:0] rec_r;
  logic [BW-1:0]           bkt_r;
  logic                    bkt_valid;
  logic [PW-1:0]           head_r;
  logic [PW-1:0]           tail_r;
  logic [PW-1:0]           cur_r;
  logic                    found_r;
  logic [RECORD_WIDTH-1:0] rec_hit_r;
  logic [CW-1:0]           pool_used;
  logic                    out_valid;
  logic                    out_hit;
  status_t                 out_status;
  logic [DATA_W-1:0]       out_record;

  // Shared multiplier.
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;

  // Memory ports.
  logic          bkt_we;
  logic [BW-1:0] bkt_waddr;
  logic [HW-1:0] bkt_wdata;
  logic [BW-1:0] bkt_calc;
  logic [HW-1:0] bkt_rd;
  logic          dat_we;
  logic [PW-1:0] dat_waddr;
  logic [DW-1:0] dat_wdata;
  logic [DW-1:0] dat_rd;
  logic          lnk_we;
  logic [PW-1:0] lnk_waddr;
  logic [LW-1:0] lnk_wdata;
  logic [LW-1:0] lnk_rd;
  logic [PW-1:0] ent_raddr;

  logic          out_free;
  logic          is_put;
  logic          pool_full;
  logic          append;
  logic [PW-1:0] new_idx;
  logic          key_match;

  assign out_free  = !out_valid || m_tready;
  assign is_put    = (cmd_r == CMD_PUT);
  assign pool_full = (pool_used >= POOL_FULL);
  assign append    = is_put && !found_r && !pool_full;
  assign new_idx   = pool_used[PW-1:0];
  assign key_match = (dat_rd[DW-1:RECORD_WIDTH] == key_r);

  // First product is key * reciprocal, the second quotient * bucket count.
  always_comb begin
    mul_a = key_r;
    mul_b = BKT_RECIP;
    if (state == S_REM) begin
      mul_a = mul_p[RECIP_SHIFT +: MUL_AW];
      mul_b = BKT_MULT;
    end
  end

  assign bkt_calc = BW'((KEY_W + 1)'(key_r) - mul_p[KEY_W:0]);

  // The chain head comes from the bucket table; later links come from the
  // link memory as they are read.
  assign ent_raddr = (state == S_WALK) ? lnk_rd[PW-1:0] : bkt_rd[2*PW-1:PW];

  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = bkt_r;
    bkt_wdata = {1'b1, (bkt_valid ? head_r : new_idx), new_idx};
    if (state == S_CLEAR) begin
      bkt_we    = 1'b1;
      bkt_waddr = clr_idx;
      bkt_wdata = '0;
    end else if (state == S_LINK) begin
      bkt_we = 1'b1;
    end
  end

  always_comb begin
    dat_we    = (state == S_DONE) && out_free && is_put && (found_r || !pool_full);
    dat_waddr = found_r ? cur_r : new_idx;
    dat_wdata = {key_r, rec_r};
  end

  // A new entry gets an empty link first; the old tail is linked to it
  // in the cycle after.
  always_comb begin
    lnk_we    = 1'b0;
    lnk_waddr = new_idx;
    lnk_wdata = '0;
    if (state == S_DONE) begin
      lnk_we = out_free && append;
    end else if (state == S_LINK) begin
      lnk_we    = bkt_valid;
      lnk_waddr = tail_r;
      lnk_wdata = {1'b1, new_idx};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      pool_used <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == BKT_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_r <= cmd_t'(s_tuser[0]);
            key_r <= s_tdata[KEY_W-1:0];
            rec_r <= s_tdata[KEY_W +: RECORD_WIDTH];
            state <= S_QUOT;
          end
        end
        S_QUOT: begin
          state <= S_REM;
        end
        S_REM: begin
          state <= S_BKT;
        end
        S_BKT: begin
          bkt_r <= bkt_calc;
          state <= S_HEAD;
        end
        S_HEAD: begin
          bkt_valid <= bkt_rd[2*PW];
          head_r    <= bkt_rd[2*PW-1:PW];
          tail_r    <= bkt_rd[PW-1:0];
          cur_r     <= bkt_rd[2*PW-1:PW];
          found_r   <= 1'b0;
          state     <= bkt_rd[2*PW] ? S_WALK : S_DONE;
        end
        S_WALK: begin
          if (key_match) begin
            found_r   <= 1'b1;
            rec_hit_r <= dat_rd[RECORD_WIDTH-1:0];
            state     <= S_DONE;
          end else if (lnk_rd[PW]) begin
            cur_r <= lnk_rd[PW-1:0];
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_hit    <= found_r;
            out_record <= (!is_put && found_r) ? DATA_W'(rec_hit_r) : '0;
            out_status <= (is_put && !found_r && pool_full) ? ST_FULL : ST_OK;
            state      <= append ? S_LINK : S_IDLE;
          end
        end
        S_LINK: begin
          pool_used <= pool_used + 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  krhm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Per bucket: valid, head, tail.
  krhm_ram #(.WIDTH(HW), .DEPTH(BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bkt_calc),
    .rdata (bkt_rd)
  );

  // Per entry: key and record.
  krhm_ram #(.WIDTH(DW), .DEPTH(POOL_ENTRIES)) u_dat_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (dat_wdata),
    .raddr (ent_raddr),
    .rdata (dat_rd)
  );

  // Per entry: next valid and next index.
  krhm_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (ent_raddr),
    .rdata (lnk_rd)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_record;
  assign m_tuser  = {out_status, out_hit};

  // The pool count never passes the pool size.
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    pool_used <= POOL_FULL)
    else $error("pool count beyond pool size");

  // The pool count only ever steps up by one.
  a_pool_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (pool_used != $past(pool_used)) |->
      (pool_used == $past(pool_used) + 1'b1))
    else $error("pool count jumped");

  // A dropped put reports neither a hit nor a record.
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1] == ST_FULL) |-> !m_tuser[0] && (m_tdata == '0))
    else $error("full status with hit or record");

  // Only one word is in work at a time.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready again right after an accepted word");

endmodule
